### sv/rlag_pkg.sv
// ----------------------------------------------------------------------------
// rlag_pkg
// Shared types, register codes and saturation helper for the actuator
// rate limit and lag block.
// ----------------------------------------------------------------------------
package rlag_pkg;

	localparam int NLANE = 4;

	typedef logic signed [31:0] q16_t;
	typedef logic [30:0]        ulim_t;
	typedef logic [16:0]        coeff_t;

	localparam coeff_t COEFF_ONE = 17'd65536;

	typedef enum logic [2:0] {
		REG_MAX_THRUST = 3'd0,
		REG_TQ_LIMIT   = 3'd1,
		REG_RATE_STEP  = 3'd2,
		REG_LAG_COEFF  = 3'd3
	} reg_idx_t;

	typedef struct packed {
		ulim_t  max_thrust;
		ulim_t  tq_limit;
		ulim_t  rate_step;
		coeff_t lag_coeff;
	} cfg_t;

	typedef struct packed {
		logic adv;
		logic s1_ready;
	} pipe_ctl_t;

	function automatic q16_t sat32(input logic signed [34:0] v);
		q16_t r;
		if (v > 35'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### sv/actuator_rate_limit_lag.sv
// ----------------------------------------------------------------------------
// actuator_rate_limit_lag
// Rate-limited first-order lag on one thrust and three torque channels,
// four lanes in parallel behind an input clamp stage.
// ----------------------------------------------------------------------------
// pipeline: clamp stage register, then lane state register
// throughput: one beat per cycle unless stalled; each lane closes its state loop
// a stalled result waits in the lane states; an empty s1 takes a new beat
// reset: clears lane states, primed flag and valids; registers take defaults
module actuator_rate_limit_lag (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  rlag_pkg::q16_t      thrust_req,
	input  rlag_pkg::q16_t      torque_cmd_x,
	input  rlag_pkg::q16_t      torque_cmd_y,
	input  rlag_pkg::q16_t      torque_cmd_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [30:0]         thrust_out,
	output rlag_pkg::q16_t      torque_out_x,
	output rlag_pkg::q16_t      torque_out_y,
	output rlag_pkg::q16_t      torque_out_z
);
	import rlag_pkg::*;

	cfg_t      cfg_q;
	logic      primed_q;
	logic      valid_s1;
	q16_t      u_s1 [NLANE];
	q16_t      x [NLANE];
	pipe_ctl_t ctl;
	coeff_t    coeff_w;

	assign cfg_ready = 1'b1;
	assign coeff_w   = (cfg_data[16:0] > COEFF_ONE) ? COEFF_ONE : cfg_data[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_thrust <= '0;
			cfg_q.tq_limit   <= '0;
			cfg_q.rate_step  <= '0;
			cfg_q.lag_coeff  <= COEFF_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_MAX_THRUST: cfg_q.max_thrust <= cfg_data[30:0];
				REG_TQ_LIMIT:   cfg_q.tq_limit   <= cfg_data[30:0];
				REG_RATE_STEP:  cfg_q.rate_step  <= cfg_data[30:0];
				REG_LAG_COEFF:  cfg_q.lag_coeff  <= coeff_w;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (ctl.adv) begin
			primed_q <= 1'b1;
		end
	end

	assign in_stall = !ctl.s1_ready;

	rlag_clamp u_clamp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.s1_ready     (ctl.s1_ready),
		.thrust_req   (thrust_req),
		.torque_cmd_x (torque_cmd_x),
		.torque_cmd_y (torque_cmd_y),
		.torque_cmd_z (torque_cmd_z),
		.cfg          (cfg_q),
		.valid_s1     (valid_s1),
		.u_s1         (u_s1)
	);

	for (genvar g = 0; g < NLANE; g++) begin : g_lane
		rlag_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (ctl.adv),
			.primed    (primed_q),
			.u         (u_s1[g]),
			.rate_step (cfg_q.rate_step),
			.lag_coeff (cfg_q.lag_coeff),
			.x         (x[g])
		);
	end

	rlag_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.out_stall    (out_stall),
		.x            (x),
		.ctl          (ctl),
		.out_valid    (out_valid),
		.thrust_out   (thrust_out),
		.torque_out_x (torque_out_x),
		.torque_out_y (torque_out_y),
		.torque_out_z (torque_out_z)
	);

endmodule

### sv/rlag_clamp.sv
// ----------------------------------------------------------------------------
// rlag_clamp
// Input stage: clamps thrust to [0, max] and each torque axis to +/- limit
// (a zero value drops that bound), then registers the four clamped commands.
// ----------------------------------------------------------------------------
module rlag_clamp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               s1_ready,
	input  rlag_pkg::q16_t     thrust_req,
	input  rlag_pkg::q16_t     torque_cmd_x,
	input  rlag_pkg::q16_t     torque_cmd_y,
	input  rlag_pkg::q16_t     torque_cmd_z,
	input  rlag_pkg::cfg_t     cfg,
	output logic               valid_s1,
	output rlag_pkg::q16_t     u_s1 [rlag_pkg::NLANE]
);
	import rlag_pkg::*;

	function automatic q16_t clamp_torque(input q16_t v, input ulim_t lim);
		logic signed [32:0] v33;
		logic signed [32:0] lim33;
		logic signed [32:0] nlim33;
		q16_t r;
		v33    = {v[31], v};
		lim33  = {2'b00, lim};
		nlim33 = -lim33;
		r      = v;
		if (lim != '0) begin
			if (v33 > lim33) begin
				r = lim33[31:0];
			end else if (v33 < nlim33) begin
				r = nlim33[31:0];
			end
		end
		return r;
	endfunction

	q16_t u_c [NLANE];
	logic load;

	always_comb begin
		u_c[0] = thrust_req;
		if (thrust_req[31]) begin
			u_c[0] = '0;
		end else if (cfg.max_thrust != '0 && thrust_req[30:0] > cfg.max_thrust) begin
			u_c[0] = {1'b0, cfg.max_thrust};
		end
		u_c[1] = clamp_torque(torque_cmd_x, cfg.tq_limit);
		u_c[2] = clamp_torque(torque_cmd_y, cfg.tq_limit);
		u_c[3] = clamp_torque(torque_cmd_z, cfg.tq_limit);
	end

	assign load = in_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			u_s1 <= u_c;
		end
	end

endmodule

### sv/rlag_lane.sv
// ----------------------------------------------------------------------------
// rlag_lane
// One actuator channel: rate limit toward the command, then first-order lag
// with round-to-nearest product and saturating sums. Holds the channel state.
// ----------------------------------------------------------------------------
module rlag_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              primed,
	input  rlag_pkg::q16_t    u,
	input  rlag_pkg::ulim_t   rate_step,
	input  rlag_pkg::coeff_t  lag_coeff,
	output rlag_pkg::q16_t    x
);
	import rlag_pkg::*;

	q16_t               x_q;
	q16_t               x_next;
	q16_t               t;
	logic signed [32:0] d;
	logic signed [32:0] r33;
	logic signed [32:0] nr33;
	logic signed [34:0] xe;
	logic signed [34:0] re;
	logic signed [32:0] diff;
	logic signed [32:0] ndiff;
	logic               neg;
	logic [31:0]        mag;
	logic [48:0]        prod;
	logic [48:0]        rnd;
	logic [32:0]        q;
	logic signed [34:0] term;
	logic signed [34:0] sum;

	always_comb begin
		r33  = {2'b00, rate_step};
		nr33 = -r33;
		xe   = {{3{x_q[31]}}, x_q};
		re   = {4'b0000, rate_step};
		d    = {u[31], u} - {x_q[31], x_q};
		t    = u;
		if (rate_step != '0) begin
			if (d > r33) begin
				t = sat32(xe + re);
			end else if (d < nr33) begin
				t = sat32(xe - re);
			end
		end
		diff  = {t[31], t} - {x_q[31], x_q};
		ndiff = -diff;
		neg   = diff[32];
		mag   = neg ? ndiff[31:0] : diff[31:0];
		prod  = {17'b0, mag} * {32'b0, lag_coeff};
		rnd   = prod + 49'd32768;
		q     = rnd[48:16];
		term  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
		sum   = xe + term;
		x_next = sat32(sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (adv) begin
			x_q <= primed ? x_next : u;
		end
	end

	assign x = x_q;

endmodule

### sv/rlag_merge.sv
// ----------------------------------------------------------------------------
// rlag_merge
// Output stage: joins the four lane states into one result beat and runs
// the stall handshake for both pipeline stages.
// ----------------------------------------------------------------------------
module rlag_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic                 out_stall,
	input  rlag_pkg::q16_t       x [rlag_pkg::NLANE],
	output rlag_pkg::pipe_ctl_t  ctl,
	output logic                 out_valid,
	output logic [30:0]          thrust_out,
	output rlag_pkg::q16_t       torque_out_x,
	output rlag_pkg::q16_t       torque_out_y,
	output rlag_pkg::q16_t       torque_out_z
);
	import rlag_pkg::*;

	logic out_valid_q;
	logic out_free;

	assign out_free     = !out_valid_q || !out_stall;
	assign ctl.adv      = valid_s1 && out_free;
	assign ctl.s1_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign thrust_out   = x[0][30:0];
	assign torque_out_x = x[1];
	assign torque_out_y = x[2];
	assign torque_out_z = x[3];

endmodule

### sv/rlag_checker.sv
// ----------------------------------------------------------------------------
// rlag_checker
// Port-level checks on the actuator rate limit and lag block.
// ----------------------------------------------------------------------------
module rlag_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [30:0] thrust_out
);

	// every accepted beat shows out_valid after passing valid_s1 and out_valid_q
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 out_valid)
		else $error("accepted beat produced no result");

	// an empty output stage never back-pressures the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(thrust_out))
		else $error("thrust result changed under stall");

endmodule

bind actuator_rate_limit_lag rlag_checker u_rlag_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.thrust_out (thrust_out)
);

### tb/actuator_rate_limit_lag_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_rate_limit_lag_chk
// Watches the register, command and result channels of the actuator rate
// limit and lag block. Keeps its own copy of the registers and of the four
// channel states. Works out the applied thrust and torques for every
// accepted command beat and compares each result beat, field by field, with
// the oldest pending prediction. Hands the mismatch and pending counts to
// the testbench top.
// ----------------------------------------------------------------------------
module actuator_rate_limit_lag_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           in_valid,
	input  logic           in_stall,
	input  rlag_pkg::q16_t thrust_req,
	input  rlag_pkg::q16_t torque_cmd_x,
	input  rlag_pkg::q16_t torque_cmd_y,
	input  rlag_pkg::q16_t torque_cmd_z,
	input  logic           out_valid,
	input  logic           out_stall,
	input  logic [30:0]    thrust_out,
	input  rlag_pkg::q16_t torque_out_x,
	input  rlag_pkg::q16_t torque_out_y,
	input  rlag_pkg::q16_t torque_out_z,
	output int             fail_count,
	output int             outstanding
);
	import rlag_pkg::*;

	typedef struct {
		logic [30:0] thrust;
		q16_t        torque[3];
	} applied_t;

	applied_t applied_q[$];

	ulim_t  thrust_max;
	ulim_t  torque_lim;
	ulim_t  step_lim;
	coeff_t lag_a;

	q16_t thrust_st;
	q16_t torque_st[3];
	logic primed;

	applied_t want;
	applied_t got;
	longint   thr;
	longint   tq[3];
	int       errs;

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// diff * a / 2^16, rounded to nearest with ties away from zero
	function automatic longint lag_share(input longint diff, input longint a);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (diff < 0) ? 64'(-diff) : 64'(diff);
		q = (mag * 64'(a) + 64'd32768) >> 16;
		return (diff < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint chan_step(input longint x, input longint u);
		longint tgt;
		longint d;
		longint r;
		longint a;
		tgt = u;
		a = (lag_a > COEFF_ONE) ? longint'(COEFF_ONE) : longint'(lag_a);
		if (step_lim != '0) begin
			d = u - x;
			r = longint'(step_lim);
			if (d > r) begin
				tgt = clip32(x + r);
			end else if (d < -r) begin
				tgt = clip32(x - r);
			end
		end
		return clip32(x + lag_share(tgt - x, a));
	endfunction

	function automatic int field_err(input string fname, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, fname, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q.delete();
			thrust_max = '0;
			torque_lim = '0;
			step_lim = '0;
			lag_a = COEFF_ONE;
			thrust_st = '0;
			for (int i = 0; i < 3; i++) begin
				torque_st[i] = '0;
			end
			primed = 1'b0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_THRUST: thrust_max = cfg_data[30:0];
					REG_TQ_LIMIT:   torque_lim = cfg_data[30:0];
					REG_RATE_STEP:  step_lim = cfg_data[30:0];
					REG_LAG_COEFF:  lag_a = cfg_data[16:0];
					default:        ;
				endcase
			end

			if (out_valid && !out_stall) begin
				got.thrust = thrust_out;
				got.torque[0] = torque_out_x;
				got.torque[1] = torque_out_y;
				got.torque[2] = torque_out_z;
				if (applied_q.size() == 0) begin
					$display("%0t unexpected result beat: thrust %h torque %h %h %h", $time,
						got.thrust, got.torque[0], got.torque[1], got.torque[2]);
					errs++;
				end else begin
					want = applied_q.pop_front();
					errs += field_err("thrust_out", {1'b0, want.thrust}, {1'b0, got.thrust});
					errs += field_err("torque_out_x", want.torque[0], got.torque[0]);
					errs += field_err("torque_out_y", want.torque[1], got.torque[1]);
					errs += field_err("torque_out_z", want.torque[2], got.torque[2]);
				end
			end

			if (in_valid && !in_stall) begin
				thr = longint'(thrust_req);
				if (thr < 0) begin
					thr = 0;
				end
				if (thrust_max != '0 && thr > longint'(thrust_max)) begin
					thr = longint'(thrust_max);
				end
				tq[0] = longint'(torque_cmd_x);
				tq[1] = longint'(torque_cmd_y);
				tq[2] = longint'(torque_cmd_z);
				for (int i = 0; i < 3; i++) begin
					if (torque_lim != '0) begin
						if (tq[i] > longint'(torque_lim)) begin
							tq[i] = longint'(torque_lim);
						end else if (tq[i] < -longint'(torque_lim)) begin
							tq[i] = -longint'(torque_lim);
						end
					end
				end
				// first beat after reset loads the states directly
				if (!primed) begin
					thrust_st = q16_t'(thr);
					for (int i = 0; i < 3; i++) begin
						torque_st[i] = q16_t'(tq[i]);
					end
					primed = 1'b1;
				end else begin
					thrust_st = q16_t'(chan_step(longint'(thrust_st), thr));
					for (int i = 0; i < 3; i++) begin
						torque_st[i] = q16_t'(chan_step(longint'(torque_st[i]), tq[i]));
					end
				end
				want.thrust = thrust_st[30:0];
				for (int i = 0; i < 3; i++) begin
					want.torque[i] = torque_st[i];
				end
				applied_q.push_back(want);
			end

			fail_count <= fail_count + errs;
			outstanding <= applied_q.size();
		end
	end

endmodule

### tb/tb_actuator_rate_limit_lag.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_actuator_rate_limit_lag
// Drives the actuator rate limit and lag block with a short directed set of
// commands (clamp extremes, full swings, rounding ties, register extremes)
// followed by random register settings and random commands under several
// idle and stall patterns, including a long receiver hold-off. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_actuator_rate_limit_lag;
	import rlag_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_BEATS = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	q16_t        thrust_req = '0;
	q16_t        torque_cmd_x = '0;
	q16_t        torque_cmd_y = '0;
	q16_t        torque_cmd_z = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [30:0] thrust_out;
	q16_t        torque_out_x;
	q16_t        torque_out_y;
	q16_t        torque_out_z;

	int   fail_count;
	int   outstanding;
	int   cycles = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   hold_left = 0;
	logic hold_arm = 1'b0;
	logic hold_seen = 1'b0;

	actuator_rate_limit_lag uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.thrust_req   (thrust_req),
		.torque_cmd_x (torque_cmd_x),
		.torque_cmd_y (torque_cmd_y),
		.torque_cmd_z (torque_cmd_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.thrust_out   (thrust_out),
		.torque_out_x (torque_out_x),
		.torque_out_y (torque_out_y),
		.torque_out_z (torque_out_z)
	);

	actuator_rate_limit_lag_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.thrust_req   (thrust_req),
		.torque_cmd_x (torque_cmd_x),
		.torque_cmd_y (torque_cmd_y),
		.torque_cmd_z (torque_cmd_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.thrust_out   (thrust_out),
		.torque_out_x (torque_out_x),
		.torque_out_y (torque_out_y),
		.torque_out_z (torque_out_z),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver side: random stall, or a long hold-off when armed
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_arm) begin
			hold_seen <= hold_arm;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_beat(input q16_t t, input q16_t x, input q16_t y, input q16_t z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		thrust_req <= t;
		torque_cmd_x <= x;
		torque_cmd_y <= y;
		torque_cmd_z <= z;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic settle;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper data bits carry junk
	task automatic load_regs(input ulim_t mt, input ulim_t tl, input ulim_t rs, input coeff_t lc);
		write_reg(REG_MAX_THRUST, {1'($urandom), mt});
		write_reg(REG_TQ_LIMIT, {1'($urandom), tl});
		write_reg(REG_RATE_STEP, {1'($urandom), rs});
		write_reg(REG_LAG_COEFF, {15'($urandom), lc});
		if ($urandom_range(2) == 0) begin
			write_reg(3'($urandom_range(7, int'(REG_LAG_COEFF) + 1)), $urandom);
		end
	endtask

	function automatic q16_t pick_cmd();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3, 4, 5: return q16_t'($urandom_range(400 << 16, 0)) - q16_t'(200 << 16);
			default: return q16_t'($urandom);
		endcase
	endfunction

	function automatic ulim_t pick_limit();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return ulim_t'($urandom);
			default: return ulim_t'($urandom_range(300 << 16, 1));
		endcase
	endfunction

	function automatic coeff_t pick_coeff();
		case ($urandom_range(5))
			0: return '0;
			1: return COEFF_ONE;
			2: return COEFF_ONE + coeff_t'($urandom_range(65535, 1));
			default: return coeff_t'($urandom_range(65535, 1));
		endcase
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: pass-through with negative thrust clamped to zero, first beat primes
		send_beat(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh00000000);
		send_beat(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'shffffffff);
		send_beat(32'shffffffff, 32'sh00000000, 32'sh00000000, 32'sh7fffffff);
		settle;

		// widest limits, coefficient above one
		load_regs('1, '1, '1, 17'h1ffff);
		send_beat(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_beat(32'sh00000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		send_beat(32'sh80000000, 32'sh80000000, 32'sh00000000, 32'sh00000001);
		settle;

		// tightest torque and rate limits, thrust max 100.0, frozen lag
		load_regs(31'h00640000, 31'd1, 31'd1, '0);
		send_beat(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh00000000);
		send_beat(32'sh00000001, 32'sh80000000, 32'sh7fffffff, 32'shffffffff);
		settle;

		// rounding ties on half and minimum coefficient
		load_regs('0, '0, '0, COEFF_ONE);
		send_beat(32'sh00000010, 32'sh00000000, 32'sh00000000, 32'sh00000100);
		settle;
		load_regs('0, '0, '0, 17'd32768);
		send_beat(32'sh00000011, 32'shffffffff, 32'sh00000003, 32'sh000000ff);
		send_beat(32'sh00000010, 32'sh00000000, 32'shfffffffd, 32'sh00000100);
		settle;
		load_regs('0, '0, '0, 17'd1);
		send_beat(32'sh00008010, 32'shffff8000, 32'sh00008000, 32'sh00000100);
		settle;

		// small rate step with no lag
		load_regs('0, 31'h00050000, 31'h00010000, COEFF_ONE);
		send_beat(32'sh00100000, 32'sh00100000, 32'shfff00000, 32'sh00000000);
		send_beat(32'sh00000000, 32'shfff00000, 32'sh00100000, 32'sh7fffffff);
		send_beat(32'sh00004000, 32'sh00000000, 32'sh00000000, 32'sh80000000);
		settle;

		// long receiver hold-off while commands keep coming
		load_regs(pick_limit(), pick_limit(), pick_limit(), pick_coeff());
		hold_arm <= ~hold_arm;
		repeat (40) send_beat(pick_cmd(), pick_cmd(), pick_cmd(), pick_cmd());
		settle;

		for (int p = 0; p < 8; p++) begin
			load_regs(pick_limit(), pick_limit(), pick_limit(), pick_coeff());
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 72;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 72;
				end
				default: begin
					send_idle_pct = 30;
					stall_pct <= 30;
				end
			endcase
			repeat (PHASE_BEATS) send_beat(pick_cmd(), pick_cmd(), pick_cmd(), pick_cmd());
			send_idle_pct = 0;
			stall_pct <= 0;
			settle;
		end

		if (fail_count == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### actuator_rate_limit_lag.f
sv/rlag_pkg.sv
sv/rlag_clamp.sv
sv/rlag_lane.sv
sv/rlag_merge.sv
sv/actuator_rate_limit_lag.sv
sv/rlag_checker.sv
tb/actuator_rate_limit_lag_chk.sv
tb/tb_actuator_rate_limit_lag.sv
